[rtl/hevc_pps_header_parser_defines.svh]
// Assertion macros shared by the PPS header parser modules.
// Depends on nothing; included inside module bodies.
`ifndef HEVC_PPS_HEADER_PARSER_DEFINES_SVH
`define HEVC_PPS_HEADER_PARSER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PPS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pps parser check failed");
// Next-cycle implication.
`define PPS_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pps parser check failed");
`endif

[rtl/pps_pkg.sv]
// Package for the PPS header parser: element kinds, codes, channel payloads
// and the kind table. Depends on nothing.
package pps_pkg;
    typedef enum logic [1:0] {
        K_FLAG  = 2'd0,
        K_BITS3 = 2'd1,
        K_UE    = 2'd2,
        K_SE    = 2'd3
    } t_kind;

    localparam logic [5:0] C_CU_QP   = 6'd12;
    localparam logic [5:0] C_QP_DEP  = 6'd13;
    localparam logic [5:0] C_CB_OFS  = 6'd14;
    localparam logic [5:0] C_TILES   = 6'd20;
    localparam logic [5:0] C_SYNC    = 6'd21;
    localparam logic [5:0] C_NCOL    = 6'd22;
    localparam logic [5:0] C_NROW    = 6'd23;
    localparam logic [5:0] C_UNIFORM = 6'd24;
    localparam logic [5:0] C_COLW    = 6'd25;
    localparam logic [5:0] C_ROWH    = 6'd26;
    localparam logic [5:0] C_LF_TILE = 6'd27;
    localparam logic [5:0] C_LF_SLC  = 6'd28;
    localparam logic [5:0] C_DBK_CTL = 6'd29;
    localparam logic [5:0] C_DBK_OVR = 6'd30;
    localparam logic [5:0] C_DBK_DIS = 6'd31;
    localparam logic [5:0] C_BETA    = 6'd32;
    localparam logic [5:0] C_SCALING = 6'd34;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_BITS = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } t_byte_item;

    typedef struct packed {
        logic [5:0]  code;
        logic [4:0]  idx;
        logic [32:0] value;
        logic        last;
        logic        done;
        logic        err;
    } t_result;

    function automatic t_kind elem_kind(input logic [5:0] code);
        t_kind k;
        begin
            unique case (code)
                6'd0, 6'd1, 6'd7, 6'd8, 6'd13, 6'd22, 6'd23, 6'd25, 6'd26: k = K_UE;
                6'd9, 6'd14, 6'd15, 6'd32, 6'd33: k = K_SE;
                6'd4: k = K_BITS3;
                default: k = K_FLAG;
            endcase
            return k;
        end
    endfunction
endpackage

[rtl/pps_stream_if.sv]
// Valid/ready channel carrying one payload struct.
// Depends on nothing.
interface pps_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/pps_bit_parser.sv]
// Bit-serial syntax engine: takes one payload bit per i_bit_vld cycle,
// reports at most one element per bit, two on tile overflow. Needs pps_pkg.
module pps_bit_parser #(
    parameter int MAX_TILE_COLUMNS = 20,
    parameter int MAX_TILE_ROWS    = 22,
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_bit_vld,
    input  logic                i_bit,
    input  logic                i_restart,
    output logic                o_finished,
    output logic                o_res_vld,
    output pps_pkg::t_result    o_res,
    output logic                o_res2_vld,
    output logic [5:0]          o_pend_code,
    output logic [4:0]          o_pend_idx
);
    import pps_pkg::*;

    logic [5:0]  r_pos, n_pos;
    logic        r_phase, n_phase;
    logic [5:0]  r_pz, n_pz;
    logic [31:0] r_acc, n_acc;
    logic [5:0]  r_rem, n_rem;
    logic [4:0]  r_flags, n_flags;
    // Counts are six bits wide so that a limit of 32 entries still fits.
    logic [5:0]  r_ncol, n_ncol, r_nrow, n_nrow, r_lc, n_lc;
    logic        r_fin, n_fin;

    t_kind       w_kind;
    logic [31:0] w_acc_sh;
    logic        w_cpl;
    logic [32:0] w_raw;
    logic [5:0]  w_nxt;
    logic [5:0]  w_lc1;
    logic [4:0]  w_idx;
    logic        w_tile_pos;

    assign w_kind   = elem_kind(r_pos);
    assign w_acc_sh = {r_acc[30:0], i_bit};
    assign w_idx    = (r_pos == C_COLW || r_pos == C_ROWH) ? r_lc[4:0] : 5'd0;
    assign w_lc1    = r_lc + 6'd1;
    assign w_tile_pos  = (r_pos == C_NCOL || r_pos == C_NROW);
    assign o_finished  = r_fin;
    assign o_pend_code = r_pos;
    assign o_pend_idx  = w_idx;

    always_comb begin
        n_pos = r_pos; n_phase = r_phase; n_pz = r_pz; n_acc = r_acc;
        n_rem = r_rem; n_flags = r_flags; n_ncol = r_ncol; n_nrow = r_nrow;
        n_lc = r_lc; n_fin = r_fin;
        w_cpl = 1'b0; w_raw = '0; w_nxt = r_pos + 6'd1;
        o_res_vld = 1'b0; o_res2_vld = 1'b0;
        o_res = '0;
        o_res.code = r_pos;
        o_res.idx  = w_idx;
        if (i_bit_vld && !r_fin) begin
            if (w_kind == K_FLAG || w_kind == K_BITS3) begin
                n_acc = w_acc_sh;
                if (r_rem <= 6'd1) begin
                    w_cpl = 1'b1;
                    w_raw = {1'b0, w_acc_sh};
                end else begin
                    n_rem = r_rem - 6'd1;
                end
            end else if (!r_phase) begin
                if (!i_bit) begin
                    n_pz = r_pz + 6'd1;
                    if (r_pz >= 6'(MAX_PREFIX_ZEROS)) begin
                        o_res_vld = 1'b1;
                        o_res.err = 1'b1;
                        n_fin = 1'b1;
                    end
                end else if (r_pz == 6'd0) begin
                    w_cpl = 1'b1;
                end else begin
                    n_phase = 1'b1;
                    n_rem = r_pz;
                    n_acc = '0;
                end
            end else begin
                n_acc = w_acc_sh;
                if (r_rem <= 6'd1) begin
                    w_cpl = 1'b1;
                    // 2^n - 1 + suffix, computed over 33 bits
                    w_raw = ((33'd1 << r_pz[4:0]) - 33'd1) + {1'b0, w_acc_sh};
                end else begin
                    n_rem = r_rem - 6'd1;
                end
            end
        end
        if (w_cpl) begin
            o_res_vld = 1'b1;
            if (w_kind == K_SE) begin
                o_res.value = w_raw[0] ? ((w_raw + 33'd1) >> 1) : (33'd0 - (w_raw >> 1));
            end else begin
                o_res.value = w_raw;
            end
            o_res.done = (r_pos == C_SCALING);
            unique case (r_pos)
                C_CU_QP: begin
                    if (w_raw[0]) n_flags[0] = 1'b1;
                    w_nxt = w_raw[0] ? C_QP_DEP : C_CB_OFS;
                end
                C_TILES: if (w_raw[0]) n_flags[1] = 1'b1;
                C_SYNC: w_nxt = r_flags[1] ? C_NCOL : C_LF_SLC;
                C_NCOL: begin
                    if (w_raw > 33'(MAX_TILE_COLUMNS)) begin
                        o_res2_vld = 1'b1; n_fin = 1'b1;
                    end
                    n_ncol = w_raw[5:0];
                end
                C_NROW: begin
                    if (w_raw > 33'(MAX_TILE_ROWS)) begin
                        o_res2_vld = 1'b1; n_fin = 1'b1;
                    end
                    n_nrow = w_raw[5:0];
                end
                C_UNIFORM: begin
                    if (w_raw[0]) n_flags[2] = 1'b1;
                    n_lc = '0;
                    w_nxt = w_raw[0] ? C_LF_TILE :
                            (r_ncol != 6'd0 ? C_COLW :
                            (r_nrow != 6'd0 ? C_ROWH : C_LF_TILE));
                end
                C_COLW: begin
                    if (w_lc1 < r_ncol) begin
                        n_lc = w_lc1; w_nxt = C_COLW;
                    end else begin
                        n_lc = '0; w_nxt = r_nrow != 6'd0 ? C_ROWH : C_LF_TILE;
                    end
                end
                C_ROWH: begin
                    if (w_lc1 < r_nrow) begin
                        n_lc = w_lc1; w_nxt = C_ROWH;
                    end else begin
                        n_lc = '0; w_nxt = C_LF_TILE;
                    end
                end
                C_DBK_CTL: begin
                    if (w_raw[0]) n_flags[3] = 1'b1;
                    w_nxt = w_raw[0] ? C_DBK_OVR : C_SCALING;
                end
                C_DBK_DIS: begin
                    if (w_raw[0]) n_flags[4] = 1'b1;
                    w_nxt = w_raw[0] ? C_SCALING : C_BETA;
                end
                C_SCALING: n_fin = 1'b1;
                default: ;
            endcase
            if (!n_fin) begin
                n_pos = w_nxt; n_phase = 1'b0; n_pz = '0; n_acc = '0;
                n_rem = (elem_kind(w_nxt) == K_BITS3) ? 6'd3 :
                        (elem_kind(w_nxt) == K_FLAG ? 6'd1 : 6'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pos <= '0; r_phase <= 1'b0; r_pz <= '0; r_acc <= '0; r_rem <= '0;
            r_flags <= '0; r_ncol <= '0; r_nrow <= '0; r_lc <= '0; r_fin <= 1'b0;
        end else begin
            r_pos <= n_pos; r_phase <= n_phase; r_pz <= n_pz; r_acc <= n_acc;
            r_rem <= n_rem; r_flags <= n_flags; r_ncol <= n_ncol; r_nrow <= n_nrow;
            r_lc <= n_lc; r_fin <= n_fin;
        end
    end

`include "hevc_pps_header_parser_defines.svh"
    `PPS_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= C_SCALING)
    `PPS_ASSERT_IMP(a_two_only_on_tile, i_clk, i_rst_n, o_res2_vld, w_tile_pos && o_res_vld)
    `PPS_ASSERT_IMP(a_lc_bound, i_clk, i_rst_n, r_pos == C_COLW, r_lc < r_ncol)
endmodule

[rtl/hevc_pps_header_parser.sv]
// Top level of the HEVC PPS header parser: byte shifter, sequencer and
// result registers. Depends on pps_pkg, pps_stream_if and pps_bit_parser.
// Usage:
//   i_in carries one payload byte and its last_byte mark per item; o_out
//   carries one decoded element per item, with code, list index, value,
//   run_last, parse_done and parse_error.
//   A byte is accepted in an idle cycle and then shifted into the bit
//   engine one bit per clock, while no second result waits and the hold
//   register can be emptied. A closing cycle marks the final result of the
//   byte with run_last and moves it to the output register; before it, a
//   byte marked last_byte adds the error result of an unfinished parse
//   and restarts the engine. A tile count overflow adds a second result.
//   Each result is kept in a hold register until the next one is found,
//   so the last result of a byte appears on o_out the cycle after its
//   closing cycle.
//   If the receiver stalls while a result is held, the shifter waits and no
//   state is lost. After a last byte the parser returns to its reset state.
//   Reset is synchronous, active low, and clears all control state.
module hevc_pps_header_parser #(
    parameter int MAX_TILE_COLUMNS = 20,
    parameter int MAX_TILE_ROWS    = 22,
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pps_stream_if.sink    i_in,
    pps_stream_if.source  o_out
);
    import pps_pkg::*;

    t_state      r_st, n_st;
    logic [7:0]  r_sh, n_sh;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_lastb, n_lastb;
    logic        r_hv, n_hv;       // a result waits in the hold register
    t_result     r_hold, n_hold;
    logic        r_ov, n_ov;
    t_result     r_out, n_out;
    logic        r_pend2, n_pend2;
    t_result     r_res2, n_res2;

    logic        w_bit_vld, w_restart, w_fin, w_rv, w_r2v, w_tail_err;
    t_result     w_res, w_err;
    logic [5:0]  w_pcode;
    logic [4:0]  w_pidx;
    logic        w_oready;

    assign w_oready = !r_ov || o_out.ready;
    assign i_in.ready = (r_st == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;
    assign w_tail_err = r_lastb && !w_fin;
    assign w_err = '{code: w_pcode, idx: w_pidx, value: '0,
                     last: 1'b0, done: 1'b0, err: 1'b1};

    // A bit is taken only when the hold slot can be emptied and no second result waits.
    assign w_bit_vld = (r_st == S_BITS) && !r_pend2 && (!r_hv || w_oready);
    assign w_restart = (r_st == S_OUT) && !r_pend2 && r_lastb &&
                       (w_fin || !r_hv || w_oready);

    pps_bit_parser #(
        .MAX_TILE_COLUMNS(MAX_TILE_COLUMNS),
        .MAX_TILE_ROWS(MAX_TILE_ROWS),
        .MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)
    ) u_bits (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_bit_vld(w_bit_vld), .i_bit(r_sh[7]),
        .i_restart(w_restart), .o_finished(w_fin), .o_res_vld(w_rv), .o_res(w_res),
        .o_res2_vld(w_r2v), .o_pend_code(w_pcode), .o_pend_idx(w_pidx)
    );

    always_comb begin
        n_st = r_st; n_sh = r_sh; n_cnt = r_cnt; n_lastb = r_lastb;
        n_hv = r_hv; n_hold = r_hold; n_pend2 = r_pend2; n_res2 = r_res2;
        n_ov = r_ov && !o_out.ready; n_out = r_out;
        unique case (r_st)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sh = i_in.data.data_byte;
                    n_lastb = i_in.data.last_byte;
                    n_cnt = '0;
                    n_st = S_BITS;
                end
            end
            S_BITS: begin
                if (r_pend2) begin
                    // Held result goes out; the overflow error takes its place.
                    if (w_oready) begin
                        n_out = r_hold; n_ov = 1'b1;
                        n_hold = r_res2; n_pend2 = 1'b0;
                    end
                end else if (w_bit_vld) begin
                    n_sh = {r_sh[6:0], 1'b0};
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd7) n_st = S_OUT;
                    if (w_rv) begin
                        if (r_hv) begin
                            n_out = r_hold; n_ov = 1'b1;
                        end
                        n_hold = w_res; n_hv = 1'b1;
                        if (w_r2v) begin
                            n_res2 = '{code: w_res.code, idx: w_res.idx, value: '0,
                                       last: 1'b0, done: 1'b0, err: 1'b1};
                            n_pend2 = 1'b1;
                        end
                    end
                end
            end
            S_OUT: begin
                if (r_pend2) begin
                    if (w_oready) begin
                        n_out = r_hold; n_ov = 1'b1;
                        n_hold = r_res2; n_pend2 = 1'b0;
                    end
                end else if (r_lastb) begin
                    // End of payload: add the error of an open parse and restart.
                    if (w_restart) begin
                        n_lastb = 1'b0;
                        if (w_tail_err) begin
                            if (r_hv) begin
                                n_out = r_hold; n_ov = 1'b1;
                            end
                            n_hold = w_err; n_hv = 1'b1;
                        end
                    end
                end else if (!r_hv) begin
                    n_st = S_IDLE;
                end else if (w_oready) begin
                    n_out = r_hold; n_out.last = 1'b1; n_ov = 1'b1;
                    n_hv = 1'b0;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_hv <= 1'b0; r_ov <= 1'b0;
            r_pend2 <= 1'b0; r_lastb <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_hv <= n_hv; r_ov <= n_ov;
            r_pend2 <= n_pend2; r_lastb <= n_lastb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh <= n_sh; r_hold <= n_hold; r_out <= n_out; r_res2 <= n_res2;
    end

`include "hevc_pps_header_parser_defines.svh"
    `PPS_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, r_st != S_IDLE, !i_in.ready)
    `PPS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 4'd8)
    `PPS_ASSERT_NXT(a_pend_clear, i_clk, i_rst_n, r_pend2 && w_oready, !r_pend2)
    `PPS_ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, r_st == S_IDLE, !r_hv && !r_pend2)
endmodule
